[rtl/core/vpu_pkg.sv]
// shared types and constants of the viewport projection block
`timescale 1ns / 1ps
`default_nettype none
package vpu_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_FWD  = 2'd0,
    OP_LOAD_INV  = 2'd1,
    OP_PROJECT   = 2'd2,
    OP_UNPROJECT = 2'd3
  } op_t;

  localparam logic [1:0] CFG_LEFT   = 2'd0;
  localparam logic [1:0] CFG_TOP    = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  // quotient bits of the viewport and w dividers
  localparam int NDC_QW = 18;
  localparam int W_QW   = 48;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [15:0]        width;
    logic [15:0]        height;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         idx;
    logic [31:0]        value;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [33:0]        num_x;
    logic [33:0]        num_y;
    logic               zero_x;
    logic               zero_y;
    logic signed [17:0] nz;
  } q_item_t;

endpackage
`default_nettype wire

[rtl/core/vpu_if.sv]
// input and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface vpu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  coef_index;
  logic [31:0] coef_value;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  modport source (output valid, opcode, coef_index, coef_value, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, opcode, coef_index, coef_value, point_x, point_y, point_z,
                output ready);
endinterface

interface vpu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        w_zero;
  modport source (output valid, out_x, out_y, out_z, w_zero, input ready);
  modport sink (input valid, out_x, out_y, out_z, w_zero, output ready);
endinterface
`default_nettype wire

[rtl/core/vpu_div.sv]
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module vpu_div #(
  parameter int DW = 32,
  parameter int QW = 48
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] rem_in,
  input  wire logic [QW-1:0] low_in,
  input  wire logic [DW-1:0] den_in,
  output logic      [QW-1:0] q_out
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];

  genvar k;
  for (k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] low_i;
    logic [QW-1:0] q_i;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_i = rem_in;
      assign den_i = den_in;
      assign low_i = low_in;
      assign q_i   = '0;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign low_i = low_r[k-1];
      assign q_i   = q_r[k-1];
    end
    assign t    = {rem_i, low_i[QW-1]};
    assign ge   = t >= {1'b0, den_i};
    assign diff = t - {1'b0, den_i};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        low_r[k] <= {low_i[QW-2:0], 1'b0};
        den_r[k] <= den_i;
        q_r[k]   <= {q_i[QW-2:0], ge};
      end
    end
  end

  assign q_out = q_r[QW-1];

endmodule
`default_nettype wire

[rtl/core/vpu_front.sv]
// front end: takes beats, decodes the opcode and prepares unproject operands
`timescale 1ns / 1ps
`default_nettype none
module vpu_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire vpu_pkg::cfg_t  cfg,
  vpu_in_if.sink              in_ch,
  output logic                f_valid,
  input  wire logic           f_ready,
  output vpu_pkg::q_item_t    f_item
);

  logic             f_valid_r;
  vpu_pkg::q_item_t f_item_r;
  vpu_pkg::q_item_t f_item_nxt;
  logic             accept;

  // clamp into the viewport span and form 2*(p - edge)
  function automatic logic [33:0] ndc_num(input logic signed [31:0] p,
                                         input logic signed [15:0] edge_px,
                                         input logic [15:0] size);
    logic signed [39:0] lo;
    logic signed [39:0] hi;
    logic signed [39:0] pp;
    logic signed [39:0] c;
    logic signed [39:0] d;
    lo = 40'(edge_px) <<< 16;
    hi = lo + $signed({8'b0, size, 16'b0});
    pp = 40'(p);
    if (pp < lo) c = lo;
    else if (pp > hi) c = hi;
    else c = pp;
    d = c - lo;
    return {d[32:0], 1'b0};
  endfunction

  function automatic logic signed [17:0] depth_ndc(input logic signed [31:0] p);
    logic signed [33:0] t;
    t = (34'(p) <<< 1) - 34'sd65536;
    if (t < -34'sd65536) return -18'sd65536;
    else if (t > 34'sd65536) return 18'sd65536;
    else return t[17:0];
  endfunction

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !f_valid_r || f_ready;

  always_comb begin
    f_item_nxt.op     = vpu_pkg::op_t'(in_ch.opcode);
    f_item_nxt.idx    = in_ch.coef_index;
    f_item_nxt.value  = in_ch.coef_value;
    f_item_nxt.px     = in_ch.point_x;
    f_item_nxt.py     = in_ch.point_y;
    f_item_nxt.pz     = in_ch.point_z;
    f_item_nxt.num_x  = ndc_num(in_ch.point_x, cfg.left, cfg.width);
    f_item_nxt.num_y  = ndc_num(in_ch.point_y, cfg.top, cfg.height);
    f_item_nxt.zero_x = cfg.width == 16'd0;
    f_item_nxt.zero_y = cfg.height == 16'd0;
    f_item_nxt.nz     = depth_ndc(in_ch.point_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (f_ready) begin
      f_valid_r <= 1'b0;
    end
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

  assign f_valid = f_valid_r;
  assign f_item  = f_item_r;

endmodule
`default_nettype wire

[rtl/core/vpu_queue.sv]
// short queue between the front end and the arithmetic back end
`timescale 1ns / 1ps
`default_nettype none
module vpu_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire vpu_pkg::q_item_t push_item,
  output logic                  pop_valid,
  input  wire logic             pop_take,
  output vpu_pkg::q_item_t      pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  vpu_pkg::q_item_t mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             push;
  logic             pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_take && pop_valid;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

[rtl/core/vpu_back.sv]
// back end: viewport divide, matrix product, w divide and viewport mapping
`timescale 1ns / 1ps
`default_nettype none
module vpu_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vpu_pkg::cfg_t    cfg,
  input  wire logic             q_valid,
  input  wire vpu_pkg::q_item_t q_item,
  output logic                  q_pop,
  vpu_out_if.source             out_ch
);

  localparam int NQ = vpu_pkg::NDC_QW;
  localparam int WQ = vpu_pkg::W_QW;

  typedef struct packed {
    logic       proj;
    logic       wz;
    logic [2:0] neg;
    logic [2:0] vneg;
    logic [2:0] vzero;
  } w_sb_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    else if (v < -50'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic [16:0] clamp01(input logic signed [49:0] v);
    if (v < 50'sd0) return 17'd0;
    else if (v > 50'sd65536) return 17'd65536;
    else return v[16:0];
  endfunction

  logic en;
  logic out_valid_r;

  // global advance: everything moves unless the output beat is stuck
  assign en    = !out_valid_r || out_ch.ready;
  assign q_pop = en && q_valid;

  // viewport divide stages
  vpu_pkg::q_item_t d_item_r [NQ];
  logic             d_valid_r [NQ];
  logic [NQ-1:0]    qx;
  logic [NQ-1:0]    qy;

  vpu_div #(.DW(16), .QW(NQ)) u_div_x (
    .clk(clk), .en(en), .rem_in(q_item.num_x[33:NQ]), .low_in(q_item.num_x[NQ-1:0]),
    .den_in(cfg.width), .q_out(qx)
  );
  vpu_div #(.DW(16), .QW(NQ)) u_div_y (
    .clk(clk), .en(en), .rem_in(q_item.num_y[33:NQ]), .low_in(q_item.num_y[NQ-1:0]),
    .den_in(cfg.height), .q_out(qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NQ; i++) d_valid_r[i] <= 1'b0;
    end else if (en) begin
      d_valid_r[0] <= q_valid;
      for (int i = 1; i < NQ; i++) d_valid_r[i] <= d_valid_r[i-1];
    end
    if (en) begin
      d_item_r[0] <= q_item;
      for (int i = 1; i < NQ; i++) d_item_r[i] <= d_item_r[i-1];
    end
  end

  // matrix stage: loads write here so they stay in order with transforms
  vpu_pkg::q_item_t   di;
  logic               dv;
  logic [31:0]        fwd_r [16];
  logic [31:0]        inv_r [16];
  logic signed [31:0] coef [16];
  logic signed [31:0] opnd [3];
  logic signed [31:0] nx;
  logic signed [31:0] ny;
  logic signed [63:0] m_prod_r [4][3];
  logic signed [31:0] m_c3_r [4];
  logic               m_valid_r;
  logic               m_proj_r;

  assign di = d_item_r[NQ-1];
  assign dv = d_valid_r[NQ-1];
  assign nx = di.zero_x ? -32'sd65536 : $signed({{(32 - NQ){1'b0}}, qx}) - 32'sd65536;
  assign ny = di.zero_y ? 32'sd65536 : 32'sd65536 - $signed({{(32 - NQ){1'b0}}, qy});

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      coef[i] = (di.op == vpu_pkg::OP_UNPROJECT) ? inv_r[i] : fwd_r[i];
    end
    if (di.op == vpu_pkg::OP_UNPROJECT) begin
      opnd[0] = nx;
      opnd[1] = ny;
      opnd[2] = 32'(di.nz);
    end else begin
      opnd[0] = di.px;
      opnd[1] = di.py;
      opnd[2] = di.pz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= dv && (di.op == vpu_pkg::OP_PROJECT || di.op == vpu_pkg::OP_UNPROJECT);
    end
    if (en && dv && di.op == vpu_pkg::OP_LOAD_FWD) fwd_r[di.idx] <= di.value;
    if (en && dv && di.op == vpu_pkg::OP_LOAD_INV) inv_r[di.idx] <= di.value;
    if (en) begin
      m_proj_r <= di.op == vpu_pkg::OP_PROJECT;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) m_prod_r[r][c] <= coef[r*4+c] * opnd[c];
        m_c3_r[r] <= coef[r*4+3];
      end
    end
  end

  // row sums, floored products
  logic signed [31:0] s_v_r [4];
  logic               s_valid_r;
  logic               s_proj_r;
  logic signed [49:0] acc [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      acc[r] = 50'(m_prod_r[r][0] >>> 16) + 50'(m_prod_r[r][1] >>> 16)
             + 50'(m_prod_r[r][2] >>> 16) + 50'(m_c3_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (en) begin
      s_valid_r <= m_valid_r;
    end
    if (en) begin
      s_proj_r <= m_proj_r;
      for (int r = 0; r < 4; r++) s_v_r[r] <= sat32(acc[r]);
    end
  end

  // divide by w on magnitudes, signs ride alongside
  logic [31:0] aw;
  logic [31:0] av [3];
  logic [WQ-1:0] wq [3];
  w_sb_t w_sb_nxt;
  w_sb_t w_sb_r [WQ];
  logic  w_valid_r [WQ];

  assign aw = s_v_r[3][31] ? 32'(-s_v_r[3]) : s_v_r[3];

  always_comb begin
    w_sb_nxt.proj = s_proj_r;
    w_sb_nxt.wz   = s_v_r[3] == 32'sd0;
    for (int r = 0; r < 3; r++) begin
      av[r]             = s_v_r[r][31] ? 32'(-s_v_r[r]) : s_v_r[r];
      w_sb_nxt.neg[r]   = s_v_r[r][31] ^ s_v_r[3][31];
      w_sb_nxt.vneg[r]  = s_v_r[r][31];
      w_sb_nxt.vzero[r] = s_v_r[r] == 32'sd0;
    end
  end

  genvar g;
  for (g = 0; g < 3; g++) begin : g_wdiv
    vpu_div #(.DW(32), .QW(WQ)) u_div_w (
      .clk(clk), .en(en), .rem_in(32'd0), .low_in({av[g], 16'd0}),
      .den_in(aw), .q_out(wq[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WQ; i++) w_valid_r[i] <= 1'b0;
    end else if (en) begin
      w_valid_r[0] <= s_valid_r;
      for (int i = 1; i < WQ; i++) w_valid_r[i] <= w_valid_r[i-1];
    end
    if (en) begin
      w_sb_r[0] <= w_sb_nxt;
      for (int i = 1; i < WQ; i++) w_sb_r[i] <= w_sb_r[i-1];
    end
  end

  // signed quotient, then clamp to 0..1 or saturate
  w_sb_t              ws;
  logic signed [49:0] qs [3];
  logic signed [49:0] h [3];
  logic [31:0]        p_nxt [3];
  logic [31:0]        p_r [3];
  logic               p_valid_r;
  logic               p_proj_r;
  logic               p_wz_r;

  assign ws = w_sb_r[WQ-1];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (ws.wz) begin
        if (ws.vzero[r]) qs[r] = 50'sd0;
        else if (ws.vneg[r]) qs[r] = -50'sd2147483648;
        else qs[r] = 50'sd2147483647;
      end else if (ws.neg[r]) begin
        qs[r] = -$signed({2'b0, wq[r]});
      end else begin
        qs[r] = $signed({2'b0, wq[r]});
      end
      h[r] = (qs[r] + 50'sd65536) >>> 1;
    end
    if (ws.proj) begin
      p_nxt[0] = 32'(clamp01(h[0]));
      p_nxt[1] = 32'(clamp01(50'sd65536 - h[1]));
      p_nxt[2] = 32'(clamp01(h[2]));
    end else begin
      for (int r = 0; r < 3; r++) p_nxt[r] = sat32(qs[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= w_valid_r[WQ-1];
    end
    if (en) begin
      p_proj_r <= ws.proj;
      p_wz_r   <= ws.wz;
      for (int r = 0; r < 3; r++) p_r[r] <= p_nxt[r];
    end
  end

  // viewport scale and output register
  logic [32:0]        mx;
  logic [32:0]        my;
  logic signed [49:0] ox;
  logic signed [49:0] oy;
  logic [31:0]        o_x_r;
  logic [31:0]        o_y_r;
  logic [31:0]        o_z_r;
  logic               o_wz_r;
  logic               o_proj_r;

  assign mx = 33'(p_r[0][16:0]) * 33'(cfg.width);
  assign my = 33'(p_r[1][16:0]) * 33'(cfg.height);
  assign ox = $signed({17'd0, mx}) + (50'(cfg.left) <<< 16);
  assign oy = $signed({17'd0, my}) + (50'(cfg.top) <<< 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p_valid_r;
    end
    if (en) begin
      o_proj_r <= p_proj_r;
      o_wz_r   <= p_wz_r;
      o_z_r    <= p_r[2];
      o_x_r    <= p_proj_r ? sat32(ox) : p_r[0];
      o_y_r    <= p_proj_r ? sat32(oy) : p_r[1];
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.out_x  = o_x_r;
  assign out_ch.out_y  = o_y_r;
  assign out_ch.out_z  = o_z_r;
  assign out_ch.w_zero = o_wz_r;

`ifndef SYNTHESIS
  a_proj_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_proj_r |-> $signed(o_z_r) >= 0 && $signed(o_z_r) <= 65536)
    else $error("project depth outside 0..1");
  a_wz_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !o_proj_r && o_wz_r |->
      o_z_r == 32'h7fffffff || o_z_r == 32'h80000000 || o_z_r == 32'h0)
    else $error("zero w did not saturate");
  a_no_load_beat: assert property (@(posedge clk) disable iff (!rst_n)
    en && dv && (di.op == vpu_pkg::OP_LOAD_FWD || di.op == vpu_pkg::OP_LOAD_INV)
      |=> !m_valid_r)
    else $error("load item reached the transform path");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(p_valid_r) && $stable(s_valid_r))
    else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

[rtl/core/viewport_project_unproject.sv]
// top level of the viewport projection and unprojection block
//
//  channel  | dir | handshake           | payload
//  in_ch    | in  | valid / ready       | opcode, coef_index, coef_value, point_x/y/z
//  out_ch   | out | valid / ready       | out_x, out_y, out_z, w_zero
//  cfg_*    | in  | cfg_we, no wait     | cfg_index, cfg_wdata
//
// one beat per cycle unless the output stalls. a beat passes the front register, the
// queue, the 18-stage viewport divider, the matrix and row-sum stages, the 48-stage w
// divider, the quotient and output registers. loads give no result beat. synchronous
// active-low reset clears control only; matrices stay undefined until loaded. an output
// stall freezes the back end; queue and front register take beats until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module viewport_project_unproject #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  vpu_in_if.sink           in_ch,
  vpu_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  vpu_pkg::cfg_t    cfg_r;
  logic             f_valid;
  logic             f_ready;
  vpu_pkg::q_item_t f_item;
  logic             q_valid;
  logic             q_pop;
  vpu_pkg::q_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left   <= 16'sd0;
      cfg_r.top    <= 16'sd0;
      cfg_r.width  <= 16'd1;
      cfg_r.height <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vpu_pkg::CFG_LEFT:   cfg_r.left   <= cfg_wdata;
        vpu_pkg::CFG_TOP:    cfg_r.top    <= cfg_wdata;
        vpu_pkg::CFG_WIDTH:  cfg_r.width  <= cfg_wdata;
        vpu_pkg::CFG_HEIGHT: cfg_r.height <= cfg_wdata;
        default:             cfg_r.left   <= cfg_r.left;
      endcase
    end
  end

  vpu_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .in_ch(in_ch),
    .f_valid(f_valid), .f_ready(f_ready), .f_item(f_item)
  );

  vpu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
    .pop_valid(q_valid), .pop_take(q_pop), .pop_item(q_item)
  );

  vpu_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .out_ch(out_ch)
  );

endmodule
`default_nettype wire

[tb/viewport_project_unproject_test.sv]
// testbench of the viewport projection block: random and directed beats checked by a scoreboard
`timescale 1ns / 1ps
module viewport_project_unproject_test;

  localparam longint ONE_Q   = 64'sd65536;
  localparam longint MAX32   = 64'sd2147483647;
  localparam longint MIN32   = -64'sd2147483648;
  localparam int     LIMIT   = 600000;
  localparam int     SETTLE  = 90;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
  } vertex_t;

  class vertex_scoreboard;
    logic [31:0] fwd_m[16];
    logic [31:0] inv_m[16];
    longint      left, top, width, height;
    vertex_t     awaited[$];
    int          mismatches;
    int          checked;
    int          wz_seen;

    function new();
      left = 0; top = 0; width = 1; height = 1;
      mismatches = 0; checked = 0; wz_seen = 0;
    endfunction

    function void set_view(longint l, longint t, longint w, longint h);
      left = l; top = t; width = w; height = h;
    endfunction

    function longint sat32(longint v);
      if (v > MAX32) return MAX32;
      if (v < MIN32) return MIN32;
      return v;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // matrix times (p0, p1, p2, 1), then divide by w
    function bit mul_div(bit use_inv, longint p[3], output longint q[3]);
      longint v[4];
      longint acc, c_val, opnd;
      bit     wz;
      for (int r = 0; r < 4; r++) begin
        acc = 0;
        for (int c = 0; c < 4; c++) begin
          c_val = use_inv ? longint'($signed(inv_m[r*4+c])) : longint'($signed(fwd_m[r*4+c]));
          opnd = (c < 3) ? p[c] : ONE_Q;
          acc += (c_val * opnd) >>> 16;
        end
        v[r] = sat32(acc);
      end
      wz = (v[3] == 0);
      for (int r = 0; r < 3; r++) begin
        if (wz) q[r] = (v[r] > 0) ? MAX32 : ((v[r] < 0) ? MIN32 : 0);
        else q[r] = (v[r] * ONE_Q) / v[3];
      end
      return wz;
    endfunction

    function longint pixel_to_ndc(longint p, longint edge_px, longint size);
      longint lo, d;
      lo = edge_px * ONE_Q;
      if (size == 0) return -ONE_Q;
      d = clip(p, lo, lo + size * ONE_Q) - lo;
      return (2 * d) / size - ONE_Q;
    endfunction

    function void note_beat(vpu_pkg::op_t op, logic [3:0] idx, logic [31:0] val,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z);
      longint  p[3], n[3], q[3], sx, sy, sz;
      vertex_t e;
      bit      wz;
      p[0] = longint'($signed(x));
      p[1] = longint'($signed(y));
      p[2] = longint'($signed(z));
      case (op)
        vpu_pkg::OP_LOAD_FWD: fwd_m[idx] = val;
        vpu_pkg::OP_LOAD_INV: inv_m[idx] = val;
        vpu_pkg::OP_PROJECT: begin
          wz = mul_div(1'b0, p, q);
          sx = clip((q[0] + ONE_Q) >>> 1, 0, ONE_Q);
          sy = clip(ONE_Q - ((q[1] + ONE_Q) >>> 1), 0, ONE_Q);
          sz = clip((q[2] + ONE_Q) >>> 1, 0, ONE_Q);
          e.x = 32'(sat32(sx * width + left * ONE_Q));
          e.y = 32'(sat32(sy * height + top * ONE_Q));
          e.z = 32'(sz);
          e.wz = wz;
          awaited.push_back(e);
        end
        default: begin
          n[0] = pixel_to_ndc(p[0], left, width);
          n[1] = -pixel_to_ndc(p[1], top, height);
          n[2] = clip(2 * p[2] - ONE_Q, -ONE_Q, ONE_Q);
          wz = mul_div(1'b1, n, q);
          e.x = 32'(sat32(q[0]));
          e.y = 32'(sat32(q[1]));
          e.z = 32'(sat32(q[2]));
          e.wz = wz;
          awaited.push_back(e);
        end
      endcase
    endfunction

    function void fail(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_beat(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic wz);
      vertex_t e;
      checked++;
      if (wz) wz_seen++;
      if (awaited.size() == 0) begin
        fail($sformatf("result beat %h %h %h %b with nothing expected", x, y, z, wz));
        return;
      end
      e = awaited.pop_front();
      if (x !== e.x) fail($sformatf("out_x exp %h got %h", e.x, x));
      if (y !== e.y) fail($sformatf("out_y exp %h got %h", e.y, y));
      if (z !== e.z) fail($sformatf("out_z exp %h got %h", e.z, z));
      if (wz !== e.wz) fail($sformatf("w_zero exp %b got %b", e.wz, wz));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  bit          lazy;
  int          cycles;
  int          beats_sent;

  vpu_in_if  in_ch ();
  vpu_out_if out_ch ();
  vertex_scoreboard sb;

  viewport_project_unproject uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && sb != null)
      sb.check_beat(out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.w_zero);
  end

  // result side stalls
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = lazy ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send(vpu_pkg::op_t op, logic [3:0] idx, logic [31:0] val,
                      logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = lazy ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= val;
    in_ch.point_x    <= x;
    in_ch.point_y    <= y;
    in_ch.point_z    <= z;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(op, idx, val, x, y, z);
    beats_sent++;
  endtask

  // wait out every result plus the pipeline of any trailing load
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_view(logic [15:0] l, logic [15:0] t, logic [15:0] w, logic [15:0] h);
    logic [15:0] vals[4];
    vals = '{l, t, w, h};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sb.set_view(longint'($signed(l)), longint'($signed(t)), longint'(w), longint'(h));
  endtask

  // mostly within +-4.0, sometimes any 32-bit value
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'd0;
      default: return 32'($urandom_range(0, 2**19) - 2**18);
    endcase
  endfunction

  function automatic logic [31:0] rand_pixel(longint edge_px, longint size);
    if ($urandom_range(0, 5) == 0) return $urandom;
    return 32'((edge_px + longint'($urandom_range(0, 40)) - 20 +
                longint'($urandom_range(0, 32'(size)))) * ONE_Q + $urandom_range(0, 65535));
  endfunction

  task automatic random_beats(int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) lazy = $urandom_range(0, 2) != 0;
      roll = $urandom_range(0, 9);
      if (roll < 2)
        send(roll ? vpu_pkg::OP_LOAD_INV : vpu_pkg::OP_LOAD_FWD, 4'($urandom), rand_q(),
             $urandom, $urandom, $urandom);
      else if (roll < 6)
        send(vpu_pkg::OP_PROJECT, 4'($urandom), $urandom, rand_q(), rand_q(), rand_q());
      else
        send(vpu_pkg::OP_UNPROJECT, 4'($urandom), $urandom,
             rand_pixel(sb.left, sb.width), rand_pixel(sb.top, sb.height),
             $urandom_range(0, 1) ? rand_q() : 32'($urandom_range(0, 65536)));
    end
  endtask

  initial begin
    sb = new();
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= vpu_pkg::CFG_LEFT;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= vpu_pkg::OP_LOAD_FWD;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    in_ch.point_x    <= '0;
    in_ch.point_y    <= '0;
    in_ch.point_z    <= '0;
    lazy = 1'b0;
    cycles = 0;
    beats_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // both matrices fully loaded before any transform reads them
    for (int i = 0; i < 16; i++) begin
      send(vpu_pkg::OP_LOAD_FWD, 4'(i), (i % 5 == 0) ? 32'(ONE_Q) : rand_q(), '0, '0, '0);
      send(vpu_pkg::OP_LOAD_INV, 4'(i), (i % 5 == 0) ? 32'(ONE_Q) : rand_q(), '0, '0, '0);
    end

    // directed: reset viewport, extremes of the points
    send(vpu_pkg::OP_PROJECT, 4'hf, 32'hffffffff, '0, '0, '0);
    send(vpu_pkg::OP_PROJECT, 4'h0, '0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send(vpu_pkg::OP_PROJECT, 4'h0, '0, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send(vpu_pkg::OP_UNPROJECT, 4'h0, '0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send(vpu_pkg::OP_UNPROJECT, 4'hf, 32'hffffffff, 32'h80000000, 32'h7fffffff,
         32'h80000000);
    send(vpu_pkg::OP_UNPROJECT, 4'h0, '0, '0, 32'h00010000, 32'h00008000);
    // zero w row: saturated quotients by sign of numerator
    for (int i = 12; i < 16; i++) begin
      send(vpu_pkg::OP_LOAD_FWD, 4'(i), '0, '0, '0, '0);
      send(vpu_pkg::OP_LOAD_INV, 4'(i), '0, '0, '0, '0);
    end
    send(vpu_pkg::OP_PROJECT, 4'h0, '0, 32'h00020000, 32'hfffe0000, '0);
    send(vpu_pkg::OP_PROJECT, 4'h0, '0, '0, '0, '0);
    send(vpu_pkg::OP_UNPROJECT, 4'h0, '0, '0, '0, 32'h00010000);
    send(vpu_pkg::OP_LOAD_FWD, 4'd15, 32'(ONE_Q), '0, '0, '0);
    send(vpu_pkg::OP_LOAD_INV, 4'd15, 32'(ONE_Q), '0, '0, '0);
    drain();

    set_view(16'd0, 16'd0, 16'd640, 16'd480);
    send(vpu_pkg::OP_PROJECT, 4'h0, '0, 32'h00008000, 32'hffff8000, 32'h00004000);
    send(vpu_pkg::OP_UNPROJECT, 4'h0, '0, 32'(320 * ONE_Q), 32'(240 * ONE_Q), 32'h00008000);
    random_beats(90);
    // hold off until every awaited result has arrived
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    random_beats(30);
    drain();

    set_view(16'h8000, 16'h8000, 16'hffff, 16'hffff);
    send(vpu_pkg::OP_UNPROJECT, 4'h0, '0, 32'h80000000, 32'h80000000, '0);
    send(vpu_pkg::OP_PROJECT, 4'h0, '0, 32'h00010000, 32'hffff0000, 32'h00010000);
    random_beats(80);
    drain();

    set_view(16'h7fff, 16'h7fff, 16'd1, 16'd1);
    send(vpu_pkg::OP_PROJECT, 4'h0, '0, 32'h00010000, 32'hffff0000, '0);
    random_beats(80);
    drain();

    // degenerate viewport of zero size
    set_view(16'd100, 16'hffce, 16'd0, 16'd0);
    send(vpu_pkg::OP_UNPROJECT, 4'h0, '0, 32'(100 * ONE_Q), '0, '0);
    send(vpu_pkg::OP_PROJECT, 4'h0, '0, 32'h00008000, 32'h00008000, '0);
    random_beats(40);
    drain();

    set_view(16'($urandom), 16'($urandom), 16'($urandom_range(1, 4096)),
             16'($urandom_range(1, 4096)));
    random_beats(130);
    drain();

    if (sb.pending() != 0) sb.fail($sformatf("%0d results never arrived", sb.pending()));
    $display("%0d beats sent, %0d results checked (%0d with zero w), %0d mismatches",
             beats_sent, sb.checked, sb.wz_seen, sb.mismatches);
    $display("viewports covered: reset, 640x480, both sign extremes, one pixel, zero size");
    if (sb.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

[sim.f]
rtl/core/vpu_pkg.sv
rtl/core/vpu_if.sv
rtl/core/vpu_div.sv
rtl/core/vpu_front.sv
rtl/core/vpu_queue.sv
rtl/core/vpu_back.sv
rtl/core/viewport_project_unproject.sv
tb/viewport_project_unproject_test.sv
